// ----- rtl/aimd_pkg.sv -----
// ----------------------------------------------------------------------------
// aimd_pkg: shared types and constants of the AIMD window sender
// Packet codes, register indexes, table geometry and the sequencer states.
// ----------------------------------------------------------------------------
package aimd_pkg;

	// table of outstanding sequence numbers
	localparam int NSLOTS  = 64;
	localparam int SLOT_AW = 6;
	localparam int SEQ_W   = 32;

	// window and threshold
	localparam int WINDOW_MAX_DEF = 64;
	localparam int THR_W          = 21;
	localparam logic [THR_W-1:0] THR_RESET = 21'h10_0000;

	// item function codes
	localparam logic FUNC_RECV = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// packet type codes
	localparam logic [1:0] PKT_NONE = 2'd0;
	localparam logic [1:0] PKT_PSH  = 2'd1;
	localparam logic [1:0] PKT_ACK  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_ID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ADD_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;

	// register reset values
	localparam logic [6:0]  ADD_STEP_RESET = 7'd1;
	localparam logic [8:0]  DEC_FACT_RESET = 9'd128;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RESP,
		ST_ACK_SCAN,
		ST_AGE_SCAN,
		ST_DECIDE,
		ST_MATCH_SCAN,
		ST_FREE_WALK,
		ST_EMIT
	} state_t;

endpackage

// ----- rtl/aimd_congestion_window_sender.sv -----
// ----------------------------------------------------------------------------
// aimd_congestion_window_sender: windowed sender with AIMD congestion window
// Answers PSH packets with ACKs, retires acknowledged sequence numbers, and on
// each send tick either backs off after a timeout or fills the window.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | dir | handshake
//  --------+------------------------------------------------+-----+----------
//  input   | func pkt_type pkt_src pkt_seq round_now        | in  | in_valid/in_ready
//  output  | out_type out_dst out_src out_seq last          | out | out_valid/out_ready
//  config  | cfg_idx cfg_wdata                              | in  | cfg_we
//
//  One slot-table walk reads the sequence/time memory at one slot per cycle
//  through a single compare unit, so its length sets how long an item holds
//  the sequencer. A received PSH waits only for the output register; a
//  received ACK walks the 64-slot table until its entry is found. A send
//  tick walks all slots for age, then decides; per emitted packet it walks
//  to the lowest free slot, skipping occupied ones, and when an outstanding
//  entry lies just ahead of the next sequence, each packet first needs a
//  match walk of the table.
//  Reset clears the valid bits at once: no clearing pass. A stalled
//  output holds the emit and response steps; in_ready is high only when idle.
//
module aimd_congestion_window_sender #(
	parameter int WINDOW_MAX = aimd_pkg::WINDOW_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [aimd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_wdata,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [1:0]                    pkt_type,
	input  logic [15:0]                   pkt_src,
	input  logic [31:0]                   pkt_seq,
	input  logic [31:0]                   round_now,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_type,
	output logic [15:0]                   out_dst,
	output logic [15:0]                   out_src,
	output logic [31:0]                   out_seq,
	output logic                          last
);

	localparam int AW  = aimd_pkg::SLOT_AW;
	localparam int NS  = aimd_pkg::NSLOTS;
	localparam int SW  = aimd_pkg::SEQ_W;
	localparam int TW  = aimd_pkg::THR_W;
	localparam int WW  = $clog2(WINDOW_MAX + 1);
	localparam int PW  = 9 + WW;

	// configuration registers
	logic [15:0] node_id_q, dest_id_q, tmo_q;
	logic [6:0]  add_step_q;
	logic [8:0]  dec_fact_q;

	// block state
	aimd_pkg::state_t state_q, state_d;
	logic [WW-1:0] window_q;
	logic [TW-1:0] thr_q;
	logic [SW-1:0] next_seq_q, prev_round_q;
	logic          prv_vld_q;
	logic [NS-1:0] slot_valid_q;

	// captured item
	logic [15:0]   pkt_src_q;
	logic [SW-1:0] pkt_seq_q, now_q;

	// walk control
	logic [AW:0]   idx_q;
	logic          chk_vld_q;
	logic [AW-1:0] chk_idx_q;
	logic [SW-1:0] rd_seq_q, rd_time_q;

	// age walk results
	logic          found_q, near_q;
	logic [AW:0]   count_q;
	logic [SW-1:0] best_q, old_seq_q, old_time_q;

	// emission
	logic [AW:0]   fp_q;
	logic [AW-1:0] emit_slot_q;
	logic          ovw_q;

	// output register
	logic          out_valid_q;
	logic [1:0]    out_type_q;
	logic [15:0]   out_dst_q, out_src_q;
	logic [SW-1:0] out_seq_q;
	logic          last_q;

	// slot memory
	logic [SW-1:0] seq_mem  [NS];
	logic [SW-1:0] time_mem [NS];

	// control decisions
	logic          scanning, issue, chk, hit, scan_done;
	logic [SW-1:0] seq_key, age;
	logic          better, near_hit;
	logic          timeout, room, emit_last, out_free;
	logic          in_acc, out_load, mem_we;
	logic          fp_free;

	// window growth and backoff arithmetic
	logic [7:0]    grow_sum;
	logic [WW-1:0] w_grow;
	logic [TW-1:0] thr_grow, thr_back;
	logic [PW-1:0] back_prod;
	logic          do_grow;

	// ------------------------------------------------------------------------
	// Shared compare unit and walk bookkeeping
	// ------------------------------------------------------------------------
	assign scanning  = (state_q == aimd_pkg::ST_ACK_SCAN) ||
	                   (state_q == aimd_pkg::ST_AGE_SCAN) ||
	                   (state_q == aimd_pkg::ST_MATCH_SCAN);
	assign chk       = chk_vld_q && scanning;
	assign seq_key   = (state_q == aimd_pkg::ST_ACK_SCAN) ? pkt_seq_q : next_seq_q;
	assign hit       = chk && slot_valid_q[chk_idx_q] && (rd_seq_q == seq_key) &&
	                   (state_q != aimd_pkg::ST_AGE_SCAN);
	assign issue     = scanning && !idx_q[AW] && !hit;
	assign scan_done = idx_q[AW] && !chk_vld_q;

	// age of an entry relative to the next sequence
	assign age      = next_seq_q - rd_seq_q;
	assign better   = !found_q || (age > best_q);
	// entry at or just ahead of next_seq: sends may have to overwrite it
	assign near_hit = (age == '0) || (&age[SW-1:AW]);

	assign timeout   = found_q && ((now_q - old_time_q) > SW'(tmo_q));
	assign room      = 8'(count_q) < 8'(window_q);
	assign emit_last = !ovw_q && ((8'(count_q) + 8'd1) >= 8'(window_q));
	assign fp_free   = !slot_valid_q[fp_q[AW-1:0]];
	assign out_free  = !out_valid_q || out_ready;

	// grow, saturate, then raise threshold to the window
	assign grow_sum = 8'(window_q) + 8'(add_step_q);
	assign w_grow   = (grow_sum > 8'(WINDOW_MAX)) ? WW'(WINDOW_MAX) : WW'(grow_sum);
	assign thr_grow = (TW'(w_grow) >= thr_q) ? TW'(w_grow) : thr_q;
	assign do_grow  = (TW'(window_q) < thr_q) || !prv_vld_q || (now_q != prev_round_q);

	// multiplicative decrease: floor(beta * window) + 1
	assign back_prod = PW'(dec_fact_q) * PW'(window_q);
	assign thr_back  = TW'(back_prod >> 8) + TW'(1);

	// ------------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			aimd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (func == aimd_pkg::FUNC_TICK)
						state_d = aimd_pkg::ST_AGE_SCAN;
					else if (pkt_type == aimd_pkg::PKT_PSH)
						state_d = aimd_pkg::ST_RESP;
					else if (pkt_type == aimd_pkg::PKT_ACK)
						state_d = aimd_pkg::ST_ACK_SCAN;
				end
			end
			aimd_pkg::ST_RESP: begin
				if (out_free)
					state_d = aimd_pkg::ST_IDLE;
			end
			aimd_pkg::ST_ACK_SCAN: begin
				if (hit || scan_done)
					state_d = aimd_pkg::ST_IDLE;
			end
			aimd_pkg::ST_AGE_SCAN: begin
				if (scan_done)
					state_d = aimd_pkg::ST_DECIDE;
			end
			aimd_pkg::ST_DECIDE: begin
				if (timeout || !room)
					state_d = aimd_pkg::ST_IDLE;
				else if (near_q)
					state_d = aimd_pkg::ST_MATCH_SCAN;
				else
					state_d = aimd_pkg::ST_FREE_WALK;
			end
			aimd_pkg::ST_MATCH_SCAN: begin
				if (hit)
					state_d = aimd_pkg::ST_EMIT;
				else if (scan_done)
					state_d = aimd_pkg::ST_FREE_WALK;
			end
			aimd_pkg::ST_FREE_WALK: begin
				if (fp_q[AW])
					state_d = aimd_pkg::ST_IDLE;
				else if (fp_free)
					state_d = aimd_pkg::ST_EMIT;
			end
			aimd_pkg::ST_EMIT: begin
				if (out_free) begin
					if (emit_last)
						state_d = aimd_pkg::ST_IDLE;
					else if (near_q)
						state_d = aimd_pkg::ST_MATCH_SCAN;
					else
						state_d = aimd_pkg::ST_FREE_WALK;
				end
			end
			default: state_d = aimd_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// State outputs
	// ------------------------------------------------------------------------
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		case (state_q)
			aimd_pkg::ST_IDLE: in_ready = 1'b1;
			aimd_pkg::ST_RESP: out_load = out_free;
			aimd_pkg::ST_EMIT: begin
				out_load = out_free;
				mem_we   = out_free;
			end
			default: ;
		endcase
	end

	assign in_acc = in_valid && in_ready;

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q  <= '0;
			dest_id_q  <= '0;
			add_step_q <= aimd_pkg::ADD_STEP_RESET;
			dec_fact_q <= aimd_pkg::DEC_FACT_RESET;
			tmo_q      <= aimd_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				aimd_pkg::CFG_NODE_ID:  node_id_q  <= cfg_wdata;
				aimd_pkg::CFG_DEST_ID:  dest_id_q  <= cfg_wdata;
				aimd_pkg::CFG_ADD_STEP: add_step_q <= cfg_wdata[6:0];
				aimd_pkg::CFG_DEC_FACT: dec_fact_q <= cfg_wdata[8:0];
				aimd_pkg::CFG_TIMEOUT:  tmo_q      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer control and window state
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= aimd_pkg::ST_IDLE;
			window_q     <= WW'(1);
			thr_q        <= aimd_pkg::THR_RESET;
			next_seq_q   <= '0;
			prev_round_q <= '0;
			prv_vld_q    <= 1'b0;
			slot_valid_q <= '0;
			idx_q        <= '0;
			chk_vld_q    <= 1'b0;
			found_q      <= 1'b0;
			near_q       <= 1'b0;
			count_q      <= '0;
			fp_q         <= '0;
			ovw_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			chk_vld_q <= issue;

			// advance the walk index, restart it outside a walk
			if (scanning)
				idx_q <= idx_q + (AW+1)'(issue);
			else
				idx_q <= '0;

			// start of a send tick
			if (in_acc && func == aimd_pkg::FUNC_TICK) begin
				found_q <= 1'b0;
				near_q  <= 1'b0;
				count_q <= '0;
			end

			// retire an acknowledged entry and, when do_grow allows, grow the window
			if (state_q == aimd_pkg::ST_ACK_SCAN && hit) begin
				slot_valid_q[chk_idx_q] <= 1'b0;
				if (do_grow) begin
					window_q <= w_grow;
					thr_q    <= thr_grow;
				end
				prev_round_q <= now_q;
				prv_vld_q    <= 1'b1;
			end

			// count outstanding entries and track the oldest
			if (state_q == aimd_pkg::ST_AGE_SCAN && chk && slot_valid_q[chk_idx_q]) begin
				count_q <= count_q + (AW+1)'(1);
				if (better)
					found_q <= 1'b1;
				if (near_hit)
					near_q <= 1'b1;
			end

			// timeout: rewind and back off; otherwise prepare to fill
			if (state_q == aimd_pkg::ST_DECIDE) begin
				fp_q <= '0;
				if (timeout) begin
					next_seq_q   <= old_seq_q;
					slot_valid_q <= '0;
					thr_q        <= thr_back;
					window_q     <= WW'(1);
				end
			end

			// reuse the slot that already holds next_seq
			if (state_q == aimd_pkg::ST_MATCH_SCAN && hit)
				ovw_q <= 1'b1;

			// find the lowest free slot
			if (state_q == aimd_pkg::ST_FREE_WALK && !fp_q[AW]) begin
				if (fp_free)
					ovw_q <= 1'b0;
				else
					fp_q <= fp_q + (AW+1)'(1);
			end

			// send one packet
			if (mem_we) begin
				slot_valid_q[emit_slot_q] <= 1'b1;
				next_seq_q <= next_seq_q + SW'(1);
				if (!ovw_q)
					count_q <= count_q + (AW+1)'(1);
			end

			// output register valid
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		chk_idx_q <= idx_q[AW-1:0];

		// capture the item
		if (in_acc) begin
			pkt_src_q <= pkt_src;
			pkt_seq_q <= pkt_seq;
			now_q     <= round_now;
		end

		// hold the oldest entry seen so far
		if (state_q == aimd_pkg::ST_AGE_SCAN && chk && slot_valid_q[chk_idx_q] && better) begin
			best_q     <= age;
			old_seq_q  <= rd_seq_q;
			old_time_q <= rd_time_q;
		end

		// pick the slot for the next packet
		if (state_q == aimd_pkg::ST_MATCH_SCAN && hit)
			emit_slot_q <= chk_idx_q;
		else if (state_q == aimd_pkg::ST_FREE_WALK && !fp_q[AW] && fp_free)
			emit_slot_q <= fp_q[AW-1:0];

		// load a result item
		if (out_load) begin
			out_src_q <= node_id_q;
			if (state_q == aimd_pkg::ST_RESP) begin
				out_type_q <= aimd_pkg::PKT_ACK;
				out_dst_q  <= pkt_src_q;
				out_seq_q  <= pkt_seq_q;
				last_q     <= 1'b1;
			end else begin
				out_type_q <= aimd_pkg::PKT_PSH;
				out_dst_q  <= dest_id_q;
				out_seq_q  <= next_seq_q;
				last_q     <= emit_last;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Slot memory: one write port, one registered read port
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			seq_mem[emit_slot_q]  <= next_seq_q;
			time_mem[emit_slot_q] <= now_q;
		end
		rd_seq_q  <= seq_mem[idx_q[AW-1:0]];
		rd_time_q <= time_mem[idx_q[AW-1:0]];
	end

	assign out_valid = out_valid_q;
	assign out_type  = out_type_q;
	assign out_dst   = out_dst_q;
	assign out_src   = out_src_q;
	assign out_seq   = out_seq_q;
	assign last      = last_q;

endmodule

// ----- rtl/aimd_chk.sv -----
// ----------------------------------------------------------------------------
// aimd_chk: port-level checks for the AIMD window sender
// Watches the result channel and the input ready over time.
// ----------------------------------------------------------------------------
module aimd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_type,
	input logic [31:0] out_seq,
	input logic        last
);

	// hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_seq) &&
		$stable(out_type) && $stable(last))
	else $error("stalled result item changed");

	// only PSH or ACK packets leave the block
	a_out_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_type == aimd_pkg::PKT_PSH || out_type == aimd_pkg::PKT_ACK))
	else $error("result item with no packet type");

	// an ACK answer is always the single result of its item
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_type == aimd_pkg::PKT_ACK |-> last)
	else $error("ACK answer not marked last");

	// no new item while a PSH burst is still unfinished
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_type == aimd_pkg::PKT_PSH && !last |-> !in_ready)
	else $error("item accepted in the middle of a PSH burst");

endmodule

bind aimd_congestion_window_sender aimd_chk u_aimd_chk (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the AIMD congestion window sender
// Feeds receive items and send ticks through a valid/ready driver, keeps a
// shadow of the window, threshold and slot table to predict every emitted
// packet, and checks the output stream in order under random stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int WIN_MAX       = aimd_pkg::WINDOW_MAX_DEF;
	localparam logic [1:0] PKT_RSVD = 2'd3;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 150;
	localparam int ROUND_ITEMS   = 40;
	localparam int MAX_PRINTS    = 100;

	typedef struct packed {
		logic        func;
		logic [1:0]  ptype;
		logic [15:0] src;
		logic [31:0] seq;
		logic [31:0] rnd;
	} link_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] dst;
		logic [15:0] src;
		logic [31:0] seq;
		logic        last;
	} packet_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic [aimd_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
	logic [15:0]                    cfg_wdata = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic                           func      = 1'b0;
	logic [1:0]                     pkt_type  = '0;
	logic [15:0]                    pkt_src   = '0;
	logic [31:0]                    pkt_seq   = '0;
	logic [31:0]                    round_now = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [1:0]                     out_type;
	logic [15:0]                    out_dst;
	logic [15:0]                    out_src;
	logic [31:0]                    out_seq;
	logic                           last;

	link_item_t items_to_send[$];
	link_item_t item_on_wire;
	packet_t    packets_due[$];
	packet_t    want_pkt;

	int fault_count   = 0;
	int idle_cycles   = 0;
	int send_gap_pct  = 0;
	int recv_gap_pct  = 0;
	int sent_in_phase = 0;
	logic [31:0] round_ctr = '0;

	// shadow of the sender state
	logic [31:0] wnd          = 32'd1;
	logic [31:0] ssthresh     = 32'(aimd_pkg::THR_RESET);
	logic [31:0] seq_next     = '0;
	logic [31:0] ack_round    = '0;
	bit          ack_round_ok = 1'b0;
	bit          slot_busy [aimd_pkg::NSLOTS];
	logic [31:0] slot_seqno [aimd_pkg::NSLOTS];
	logic [31:0] slot_stamp [aimd_pkg::NSLOTS];

	// shadow of the registers
	logic [15:0] node_addr = '0;
	logic [15:0] dest_addr = '0;
	logic [6:0]  step      = aimd_pkg::ADD_STEP_RESET;
	logic [8:0]  beta      = aimd_pkg::DEC_FACT_RESET;
	logic [15:0] rto       = aimd_pkg::TIMEOUT_RESET;

	aimd_congestion_window_sender dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.pkt_type  (pkt_type),
		.pkt_src   (pkt_src),
		.pkt_seq   (pkt_seq),
		.round_now (round_now),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_type  (out_type),
		.out_dst   (out_dst),
		.out_src   (out_src),
		.out_seq   (out_seq),
		.last      (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (fault_count < MAX_PRINTS)
			$display("mismatch at %0t: %s", $realtime, what);
		fault_count++;
	endtask

	// additive increase, saturate, then drag the threshold up
	function automatic void widen_window();
		logic [31:0] w;
		w = wnd + 32'(step);
		if (w > WIN_MAX)
			w = WIN_MAX;
		wnd = w;
		if (wnd >= ssthresh)
			ssthresh = wnd;
	endfunction

	// work out the packets that one accepted item causes
	task automatic predict_emitted(input link_item_t it);
		int i, cnt, oldest, n, slot;
		logic [31:0] age, best, dt;
		packet_t p;
		if (it.func == aimd_pkg::FUNC_RECV) begin
			if (it.ptype == aimd_pkg::PKT_PSH) begin
				p = {aimd_pkg::PKT_ACK, it.src, node_addr, it.seq, 1'b1};
				packets_due.insert(packets_due.size(), p);
			end else if (it.ptype == aimd_pkg::PKT_ACK) begin
				for (i = 0; i < aimd_pkg::NSLOTS; i++) begin
					if (slot_busy[i] && slot_seqno[i] == it.seq) begin
						slot_busy[i] = 1'b0;
						// at or above the threshold grow at most once per round
						if (wnd >= ssthresh) begin
							if (!ack_round_ok || it.rnd != ack_round)
								widen_window();
						end else begin
							widen_window();
						end
						ack_round    = it.rnd;
						ack_round_ok = 1'b1;
						break;
					end
				end
			end
			return;
		end
		// find the entry sent earliest
		cnt    = 0;
		oldest = -1;
		best   = '0;
		for (i = 0; i < aimd_pkg::NSLOTS; i++) begin
			if (slot_busy[i]) begin
				age = seq_next - slot_seqno[i];
				cnt++;
				if (oldest < 0 || age > best) begin
					best   = age;
					oldest = i;
				end
			end
		end
		if (oldest >= 0) begin
			dt = it.rnd - slot_stamp[oldest];
			if (dt > 32'(rto)) begin
				// back off: rewind, clear the table, shrink the window
				seq_next = slot_seqno[oldest];
				for (i = 0; i < aimd_pkg::NSLOTS; i++)
					slot_busy[i] = 1'b0;
				ssthresh = ((32'(beta) * wnd) >> 8) + 32'd1;
				wnd      = 32'd1;
				return;
			end
		end
		// fill the window
		n = 0;
		while (cnt < int'(wnd)) begin
			slot = -1;
			for (i = 0; i < aimd_pkg::NSLOTS; i++) begin
				if (slot_busy[i] && slot_seqno[i] == seq_next) begin
					slot = i;
					break;
				end
			end
			if (slot < 0) begin
				for (i = 0; i < aimd_pkg::NSLOTS; i++) begin
					if (!slot_busy[i]) begin
						slot = i;
						break;
					end
				end
				if (slot < 0)
					break;
				cnt++;
			end
			slot_busy[slot]  = 1'b1;
			slot_seqno[slot] = seq_next;
			slot_stamp[slot] = it.rnd;
			p = {aimd_pkg::PKT_PSH, dest_addr, node_addr, seq_next, 1'b0};
			packets_due.insert(packets_due.size(), p);
			n++;
			seq_next++;
		end
		if (n > 0) begin
			p = packets_due.pop_back();
			p.last = 1'b1;
			packets_due.insert(packets_due.size(), p);
		end
	endtask

	// drive input items from the pending queue, hold each until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				predict_emitted(item_on_wire);
			if (!in_valid || in_ready) begin
				if (items_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
					item_on_wire = items_to_send.pop_front();
					in_valid  <= 1'b1;
					func      <= item_on_wire.func;
					pkt_type  <= item_on_wire.ptype;
					pkt_src   <= item_on_wire.src;
					pkt_seq   <= item_on_wire.seq;
					round_now <= item_on_wire.rnd;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// check each accepted packet against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (packets_due.size() == 0) begin
					report_mismatch($sformatf("unexpected packet type %0d seq %h",
						out_type, out_seq));
				end else begin
					want_pkt = packets_due.pop_front();
					if (out_type !== want_pkt.kind || out_dst !== want_pkt.dst ||
					    out_src !== want_pkt.src || out_seq !== want_pkt.seq ||
					    last !== want_pkt.last)
						report_mismatch($sformatf(
							"got %0d/%h/%h/%h/%b want %0d/%h/%h/%h/%b",
							out_type, out_dst, out_src, out_seq, last,
							want_pkt.kind, want_pkt.dst, want_pkt.src,
							want_pkt.seq, want_pkt.last));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// count cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(negedge clk);
		$display("status: fail");
		$finish;
	end

	task automatic queue_item(input logic f, input logic [1:0] t, input logic [15:0] s,
		input logic [31:0] q, input logic [31:0] r);
		link_item_t it;
		it = {f, t, s, q, r};
		items_to_send.insert(items_to_send.size(), it);
		sent_in_phase++;
	endtask

	task automatic wait_accepted();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || in_valid);
	endtask

	task automatic wait_drained();
		wait_accepted();
		while (packets_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [aimd_pkg::CFG_IDX_W-1:0] idx,
		input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			aimd_pkg::CFG_NODE_ID:  node_addr = val;
			aimd_pkg::CFG_DEST_ID:  dest_addr = val;
			aimd_pkg::CFG_ADD_STEP: step      = val[6:0];
			aimd_pkg::CFG_DEC_FACT: beta      = val[8:0];
			aimd_pkg::CFG_TIMEOUT:  rto       = val;
			default: ;
		endcase
	endtask

	// settle the block, pick the idling mix, then load all registers
	task automatic load_config(input int mode, input logic [15:0] n, input logic [15:0] d,
		input logic [15:0] s, input logic [15:0] b, input logic [15:0] t);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		case (mode)
			0: begin
				send_gap_pct = 29;
				recv_gap_pct = 51;
			end
			1: begin
				send_gap_pct = 51;
				recv_gap_pct = 29;
			end
			default: begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
		endcase
		write_reg(aimd_pkg::CFG_NODE_ID, n);
		write_reg(aimd_pkg::CFG_DEST_ID, d);
		write_reg(aimd_pkg::CFG_ADD_STEP, s);
		write_reg(aimd_pkg::CFG_DEC_FACT, b);
		write_reg(aimd_pkg::CFG_TIMEOUT, t);
	endtask

	// one round: a send tick, then acks for most outstanding entries, with noise
	task automatic play_round();
		logic [31:0] open_seqs [aimd_pkg::NSLOTS];
		logic [31:0] tmp, ack_rnd;
		int n_open, i, j, pick;
		queue_item(aimd_pkg::FUNC_TICK, 2'($urandom_range(3)), 16'($urandom), $urandom,
			round_ctr);
		wait_accepted();
		n_open = 0;
		for (i = 0; i < aimd_pkg::NSLOTS; i++) begin
			if (slot_busy[i]) begin
				open_seqs[n_open] = slot_seqno[i];
				n_open++;
			end
		end
		// shuffle so acks arrive out of order
		for (i = n_open - 1; i > 0; i--) begin
			j            = $urandom_range(i);
			tmp          = open_seqs[i];
			open_seqs[i] = open_seqs[j];
			open_seqs[j] = tmp;
		end
		for (i = 0; (i < n_open || i == 0) && sent_in_phase < ROUND_ITEMS; i++) begin
			if (i < n_open && $urandom_range(99) < 70) begin
				ack_rnd = ($urandom_range(9) == 0) ? round_ctr + 32'd1 : round_ctr;
				queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'($urandom),
					open_seqs[i], ack_rnd);
				if ($urandom_range(19) == 0)
					queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'($urandom),
						open_seqs[i], ack_rnd);
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_PSH, 16'($urandom),
					$urandom, $urandom);
			end else if (pick < 11) begin
				queue_item(aimd_pkg::FUNC_RECV,
					($urandom_range(1) == 0) ? aimd_pkg::PKT_NONE : PKT_RSVD,
					16'($urandom), $urandom, $urandom);
			end else if (pick < 14) begin
				queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'($urandom),
					$urandom, round_ctr);
			end
		end
		// advance the round: mostly by one, sometimes past the timeout
		pick = $urandom_range(99);
		if (pick < 12)
			round_ctr = round_ctr + 32'(rto) + 32'd1 + $urandom_range(3);
		else if (pick < 88)
			round_ctr = round_ctr + 32'd1;
	endtask

	task automatic random_rounds();
		sent_in_phase = 0;
		while (sent_in_phase < ROUND_ITEMS) begin
			play_round();
			// hold the sender until every packet has come out
			if ($urandom_range(9) == 0)
				wait_drained();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_config(0, 16'hFFFF, 16'h0000, 16'd1, 16'd128, 16'd3);
		// directed: field extremes, ignored types, slow start, growth per round,
		// timeout with backoff
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_PSH, 16'h0000, 32'h0000_0000,
			32'h0000_0000);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_PSH, 16'hFFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_NONE, 16'h1234, 32'h0000_0000, 32'd0);
		queue_item(aimd_pkg::FUNC_RECV, PKT_RSVD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0001, 32'd0, 32'd0);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd0);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h00AA, 32'd0, 32'd0);
		queue_item(aimd_pkg::FUNC_TICK, PKT_RSVD, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0002, 32'd2, 32'd1);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0002, 32'd2, 32'd1);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0003, 32'd1, 32'd1);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd2);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd9);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd9);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0004, 32'd3, 32'd9);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd10);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0005, 32'd4, 32'd10);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0006, 32'd5, 32'd10);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd11);
		queue_item(aimd_pkg::FUNC_RECV, aimd_pkg::PKT_ACK, 16'h0007, 32'd6, 32'd11);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd14);
		queue_item(aimd_pkg::FUNC_TICK, aimd_pkg::PKT_NONE, 16'h0000, 32'd0, 32'd15);
		wait_accepted();
		round_ctr = 32'd16;
		random_rounds();

		load_config(0, 16'h0000, 16'hFFFF, 16'd64, 16'd256, 16'd0);
		random_rounds();

		// round counter wraps during this phase
		load_config(1, 16'($urandom), 16'($urandom), 16'd127, 16'd511, 16'hFFFF);
		round_ctr = 32'hFFFF_FFF0;
		random_rounds();

		// zero step: the window never grows
		load_config(1, 16'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd1);
		random_rounds();

		load_config(2, 16'($urandom), 16'($urandom), 16'd3, 16'd200, 16'd2);
		random_rounds();

		load_config(2, 16'($urandom), 16'($urandom), 16'd1, 16'd128, 16'd5);
		random_rounds();

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (packets_due.size() != 0)
			report_mismatch($sformatf("%0d packets never arrived", packets_due.size()));
		if (fault_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/aimd_pkg.sv
rtl/aimd_congestion_window_sender.sv
rtl/aimd_chk.sv
sim/tb.sv
